[hw/rtl/brf_pkg.sv]
package brf_pkg;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_LOGIC   = 3'd2,
        OP_ADD     = 3'd3,
        OP_SUB     = 3'd4,
        OP_COND    = 3'd5,
        OP_ADV_PC  = 3'd6,
        OP_NOP     = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_REG = 2'd1,
        ST_NO_SPSR = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;
    localparam logic [4:0] MODE_SYS = 5'h1F;

    localparam logic [4:0] REG_PC   = 5'd15;
    localparam logic [4:0] REG_CPSR = 5'd16;
    localparam logic [4:0] REG_SPSR = 5'd17;

    localparam logic [31:0] PC_RESET = 32'h0800_0000;
    localparam logic [31:0] PC_STEP_ARM   = 32'd4;
    localparam logic [31:0] PC_STEP_THUMB = 32'd2;

    localparam int NUM_BANKS = 6;
    localparam int NUM_SPSR  = 5;

    typedef logic [2:0] t_bank;

    // 0 user/system, 1 fiq, 2 svc, 3 abt, 4 irq, 5 und
    function automatic t_bank bank_of(input logic [4:0] mode);
        t_bank b;
        case (mode)
            MODE_FIQ: b = 3'd1;
            MODE_SVC: b = 3'd2;
            MODE_ABT: b = 3'd3;
            MODE_IRQ: b = 3'd4;
            MODE_UND: b = 3'd5;
            default:  b = 3'd0;
        endcase
        return b;
    endfunction

    function automatic logic mode_valid(input logic [4:0] mode);
        return (mode == MODE_USR) || (mode == MODE_FIQ) || (mode == MODE_IRQ) ||
               (mode == MODE_SVC) || (mode == MODE_ABT) || (mode == MODE_UND) ||
               (mode == MODE_SYS);
    endfunction

    function automatic logic cond_holds(input logic [3:0] cond, input logic n,
                                        input logic z, input logic c, input logic v);
        logic h;
        case (cond)
            4'd0:    h = z;
            4'd1:    h = !z;
            4'd2:    h = c;
            4'd3:    h = !c;
            4'd4:    h = n;
            4'd5:    h = !n;
            4'd6:    h = v;
            4'd7:    h = !v;
            4'd8:    h = c && !z;
            4'd9:    h = !c || z;
            4'd10:   h = (n == v);
            4'd11:   h = (n != v);
            4'd12:   h = !z && (n == v);
            4'd13:   h = z || (n != v);
            4'd14:   h = 1'b1;
            default: h = 1'b0;
        endcase
        return h;
    endfunction

endpackage

[hw/rtl/banked_register_file_with_status_unit.sv]
// channel   valid        ready        payload
// request   i_in_valid   o_in_ready   i_opcode i_reg_index i_data_value i_operand_a
//                                     i_operand_b i_shifter_carry i_condition
// result    o_out_valid  i_out_ready  o_read_data o_condition_true o_status
//
// One request per cycle unless the result stalls; path: input register, then decode, bank
// access and flag logic into the result register, where the register file updates.
// Synchronous active-low reset clears the banks and valids, PC to 0x08000000, CPSR to 0xDF.
// A stalled result holds the request in the input register; o_in_ready then drops.
module banked_register_file_with_status_unit
    import brf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [4:0]  i_reg_index,
    input  logic [31:0] i_data_value,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic        i_shifter_carry,
    input  logic [3:0]  i_condition,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic        o_condition_true,
    output logic [1:0]  o_status
);

    logic        r_in_valid;
    t_opcode     r_op;
    logic [4:0]  r_idx;
    logic [31:0] r_d;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic        r_sc;
    logic [3:0]  r_cond;

    logic [31:0] r_low  [8];
    logic [31:0] r_usr_hi [5];
    logic [31:0] r_fiq_hi [5];
    logic [31:0] r_sp   [NUM_BANKS];
    logic [31:0] r_lr   [NUM_BANKS];
    logic [31:0] r_spsr [NUM_SPSR];
    logic [31:0] r_pc;
    logic        r_n, r_z, r_c, r_v, r_i, r_f, r_t;
    logic [4:0]  r_mode;

    logic        r_out_valid;
    logic [31:0] r_rd;
    logic        r_ct;
    t_status     r_st;

    logic        adv;
    t_bank       bk;
    logic        is_fiq;
    logic [2:0]  hi_idx;
    t_bank       spsr_idx;
    logic [31:0] cpsr_word;
    logic        is_rd;
    logic        n_n, n_z, n_c, n_v, n_i, n_f, n_t;
    logic [4:0]  n_mode;
    logic [31:0] n_rd;
    logic        n_ct;
    t_status     n_st;
    logic [31:0] n_pc;
    logic        wr_gpr;
    logic        wr_spsr;
    logic        a_s, b_s, d_s;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    assign bk        = bank_of(r_mode);
    assign is_fiq    = (r_mode == MODE_FIQ);
    assign hi_idx    = 3'(r_idx - 5'd8);
    assign spsr_idx  = bk - 3'd1;
    assign cpsr_word = {r_n, r_z, r_c, r_v, 20'd0, r_i, r_f, r_t, r_mode};
    assign is_rd     = (r_op == OP_READ);
    assign a_s       = r_a[31];
    assign b_s       = r_b[31];
    assign d_s       = r_d[31];

    always_comb begin
        n_n = r_n; n_z = r_z; n_c = r_c; n_v = r_v;
        n_i = r_i; n_f = r_f; n_t = r_t; n_mode = r_mode;
        n_rd = '0;
        n_ct = 1'b0;
        n_st = ST_OK;
        n_pc = r_pc;
        wr_gpr = 1'b0;
        wr_spsr = 1'b0;
        case (r_op)
            OP_READ, OP_WRITE: begin
                if (r_idx > REG_SPSR) begin
                    n_st = ST_BAD_REG;
                end else if (r_idx == REG_SPSR) begin
                    if (bk == 3'd0) begin
                        n_st = ST_NO_SPSR;
                    end else if (is_rd) begin
                        n_rd = r_spsr[spsr_idx];
                    end else begin
                        wr_spsr = 1'b1;
                    end
                end else if (r_idx == REG_CPSR) begin
                    if (is_rd) begin
                        n_rd = cpsr_word;
                    end else begin
                        {n_n, n_z, n_c, n_v} = r_d[31:28];
                        if (r_mode != MODE_USR) begin
                            n_i = r_d[7];
                            n_f = r_d[6];
                            n_t = r_d[5];
                            if (mode_valid(r_d[4:0]) &&
                                !(r_d[4:0] == MODE_FIQ && r_f) &&
                                !(r_d[4:0] == MODE_IRQ && r_i)) begin
                                n_mode = r_d[4:0];
                            end
                        end
                    end
                end else begin
                    if (is_rd) begin
                        if (r_idx < 5'd8) begin
                            n_rd = r_low[r_idx[2:0]];
                        end else if (r_idx < 5'd13) begin
                            n_rd = is_fiq ? r_fiq_hi[hi_idx] : r_usr_hi[hi_idx];
                        end else if (r_idx == 5'd13) begin
                            n_rd = r_sp[bk];
                        end else if (r_idx == 5'd14) begin
                            n_rd = r_lr[bk];
                        end else begin
                            n_rd = r_pc;
                        end
                    end else begin
                        wr_gpr = 1'b1;
                        if (r_idx == REG_PC) begin
                            n_pc = r_d;
                        end
                    end
                end
            end
            OP_LOGIC: begin
                n_c = r_sc;
                n_z = (r_d == '0);
                n_n = d_s;
            end
            OP_ADD: begin
                n_c = (r_a > r_d) || (r_b > r_d);
                n_z = (r_d == '0);
                n_n = d_s;
                n_v = (a_s == b_s) && (d_s != a_s);
            end
            OP_SUB: begin
                n_c = (r_a >= r_b);
                n_z = (r_d == '0);
                n_n = d_s;
                n_v = (a_s != b_s) && (d_s != a_s);
            end
            OP_COND: begin
                n_ct = cond_holds(r_cond, r_n, r_z, r_c, r_v);
            end
            OP_ADV_PC: begin
                n_pc = r_pc + (r_t ? PC_STEP_THUMB : PC_STEP_ARM);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op   <= t_opcode'(i_opcode);
            r_idx  <= i_reg_index;
            r_d    <= i_data_value;
            r_a    <= i_operand_a;
            r_b    <= i_operand_b;
            r_sc   <= i_shifter_carry;
            r_cond <= i_condition;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) r_low[k] <= '0;
            for (int k = 0; k < 5; k++) begin
                r_usr_hi[k] <= '0;
                r_fiq_hi[k] <= '0;
            end
            for (int k = 0; k < NUM_BANKS; k++) begin
                r_sp[k] <= '0;
                r_lr[k] <= '0;
            end
            for (int k = 0; k < NUM_SPSR; k++) r_spsr[k] <= '0;
            r_pc   <= PC_RESET;
            {r_n, r_z, r_c, r_v} <= 4'b0000;
            r_i    <= 1'b1;
            r_f    <= 1'b1;
            r_t    <= 1'b0;
            r_mode <= MODE_SYS;
        end else if (adv) begin
            r_pc <= n_pc;
            {r_n, r_z, r_c, r_v} <= {n_n, n_z, n_c, n_v};
            r_i    <= n_i;
            r_f    <= n_f;
            r_t    <= n_t;
            r_mode <= n_mode;
            if (wr_spsr) begin
                r_spsr[spsr_idx] <= r_d;
            end
            if (wr_gpr) begin
                if (r_idx < 5'd8) begin
                    r_low[r_idx[2:0]] <= r_d;
                end else if (r_idx < 5'd13) begin
                    if (is_fiq) begin
                        r_fiq_hi[hi_idx] <= r_d;
                    end else begin
                        r_usr_hi[hi_idx] <= r_d;
                    end
                end else if (r_idx == 5'd13) begin
                    r_sp[bk] <= r_d;
                end else if (r_idx == 5'd14) begin
                    r_lr[bk] <= r_d;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd <= n_rd;
            r_ct <= n_ct;
            r_st <= n_st;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_rd;
    assign o_condition_true = r_ct;
    assign o_status         = r_st;

    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_read_data == '0))
        else $error("error result carries data");

    a_cond_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_condition_true) |-> (o_status == ST_OK))
        else $error("condition result with error status");

    a_mode_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mode_valid(r_mode))
        else $error("illegal mode in status word");

    a_hold_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_d) && $stable(r_idx)))
        else $error("stalled request lost");

    a_no_adv_hold_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv && $past(i_rst_n)) |=> $stable(r_pc))
        else $error("pc changed without request");

endmodule
